[rtl/core/lzss_pkg.sv]
// Shared types and constants for the LZSS window decompressor.
// Used by lzss_window_ram, lzss_copy_engine and lzss_window_decompressor.
`default_nettype none

package lzss_pkg;

  // Window geometry
  localparam int WINDOW_DEPTH = 1024;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = WIN_AW + 1;
  localparam logic [WIN_AW-1:0] START_POS = WIN_AW'(958);

  // Output grouping: four byte slots per result, OUT_LANES of them used
  localparam int OUT_LANES  = 4;
  localparam int LANE_SLOTS = 4;
  localparam int LANES      = (OUT_LANES > LANE_SLOTS) ? LANE_SLOTS :
                              ((OUT_LANES < 1) ? 1 : OUT_LANES);
  localparam int LANE_IW    = $clog2(LANE_SLOTS);
  localparam int COUNT_W    = 3;

  // Token decoding
  localparam int LEN_W  = 7;
  localparam int REM_W  = 24;
  localparam logic [15:0] FLAG_FILL = 16'hFF00;
  localparam logic [7:0]  POS_MASK  = 8'hC0;
  localparam logic [7:0]  LEN_MASK  = 8'h3F;
  localparam logic [LEN_W-1:0] MIN_MATCH = LEN_W'(3);

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_byte0;
    logic [7:0]         out_byte1;
    logic [7:0]         out_byte2;
    logic [7:0]         out_byte3;
    logic [COUNT_W-1:0] byte_count;
    logic               last_of_run;
    logic               stream_done;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_TOKEN,
    PH_FLAG_DONE,
    PH_HIGH
  } phase_t;

  typedef enum logic [1:0] {
    REQ_NONE,
    REQ_START,
    REQ_LITERAL,
    REQ_COPY
  } req_kind_t;

  typedef enum logic {
    E_IDLE,
    E_COPY
  } eng_state_t;

  // Work handed from the token parser to the copy engine
  typedef struct packed {
    req_kind_t         kind;
    logic [7:0]        data;
    logic [WIN_AW-1:0] pos;
    logic [LEN_W-1:0]  len;
    logic [REM_W-1:0]  length;
  } eng_req_t;

endpackage

`default_nettype wire

[rtl/core/lzss_window_ram.sv]
// History window storage: one write port, one registered read port.
// Depends on lzss_pkg for the window geometry.
`default_nettype none

module lzss_window_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [lzss_pkg::WIN_AW-1:0] waddr,
  input  wire logic [7:0]                wdata,
  input  wire logic [lzss_pkg::WIN_AW-1:0] raddr,
  output logic [7:0]                     rdata
);
  import lzss_pkg::*;

  logic [7:0] mem [WINDOW_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/lzss_copy_engine.sv]
// Copy engine: writes literals and back-reference bytes into the window,
// reads it one byte a cycle with forwarding while a lane is free; packs result groups.
// Depends on lzss_pkg and lzss_window_ram.
`default_nettype none

module lzss_copy_engine (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire lzss_pkg::eng_req_t         req,
  input  wire logic                       grp_free,
  output logic                            idle,
  output logic [lzss_pkg::REM_W-1:0]      remaining,
  output logic                            grp_push,
  output lzss_pkg::out_item_t             grp
);
  import lzss_pkg::*;

  eng_state_t state, state_next;

  logic [WIN_AW-1:0] wp;
  logic [FILL_W-1:0] fill;
  logic [WIN_AW-1:0] rd_addr;
  logic [LEN_W-1:0]  cnt_left;
  logic              p_valid;
  logic              p_fwd;
  logic [7:0]        p_fwd_data;
  logic              p_zero;
  logic [7:0]        lanes [LANE_SLOTS];
  logic [COUNT_W-1:0] lane_n;

  logic [7:0]        ram_q;
  logic              wr_en;
  logic [7:0]        wr_data;
  logic [7:0]        arr_byte;
  logic              issue;
  logic              written;
  logic [WIN_AW-1:0] rd_off;
  logic [LEN_W-1:0]  eff_len;
  logic [COUNT_W:0]  lane_sum;
  logic              take_lit;
  logic              take_copy;

  lzss_window_ram u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wp),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      E_IDLE: begin
        if (req.kind == REQ_LITERAL || req.kind == REQ_COPY) begin
          state_next = E_COPY;
        end
      end
      E_COPY: begin
        if (grp_push && cnt_left == '0) begin
          state_next = E_IDLE;
        end
      end
      default: state_next = E_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    idle      = (state == E_IDLE);
    take_lit  = idle && (req.kind == REQ_LITERAL);
    take_copy = idle && (req.kind == REQ_COPY);

    // Pick the arriving byte: forwarded, never written, or from the RAM
    if (p_fwd) begin
      arr_byte = p_fwd_data;
    end else if (p_zero) begin
      arr_byte = 8'h00;
    end else begin
      arr_byte = ram_q;
    end

    wr_en   = take_lit || (state == E_COPY && p_valid);
    wr_data = take_lit ? req.data : arr_byte;

    // Close a group when full, or when the run has drained
    grp_push = (state == E_COPY) && !p_valid && grp_free &&
               (lane_n == COUNT_W'(LANES) || (cnt_left == '0 && lane_n != '0));

    // Issue a read only if the returning byte has a slot
    lane_sum = (COUNT_W+1)'(lane_n) + (COUNT_W+1)'(p_valid);
    issue    = (state == E_COPY) && (cnt_left != '0) &&
               (lane_sum <= (COUNT_W+1)'(LANES - 1) || grp_push);

    // An entry is valid if it lies within the bytes written since start
    rd_off  = rd_addr - START_POS;
    written = {1'b0, rd_off} < fill;

    // Clip the copy to what the stream still needs
    eff_len = (remaining < REM_W'(req.len)) ? remaining[LEN_W-1:0] : req.len;

    grp.out_byte0   = (lane_n > COUNT_W'(0)) ? lanes[0] : 8'h00;
    grp.out_byte1   = (lane_n > COUNT_W'(1)) ? lanes[1] : 8'h00;
    grp.out_byte2   = (lane_n > COUNT_W'(2)) ? lanes[2] : 8'h00;
    grp.out_byte3   = (lane_n > COUNT_W'(3)) ? lanes[3] : 8'h00;
    grp.byte_count  = lane_n;
    grp.last_of_run = (cnt_left == '0);
    grp.stream_done = (remaining == '0);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      wp        <= START_POS;
      fill      <= '0;
      remaining <= '0;
      cnt_left  <= '0;
      p_valid   <= 1'b0;
      p_fwd     <= 1'b0;
      lane_n    <= '0;
    end else begin
      state   <= state_next;
      p_valid <= issue;
      p_fwd   <= issue && wr_en && (rd_addr == wp);

      if (idle && req.kind == REQ_START) begin
        wp        <= START_POS;
        fill      <= '0;
        remaining <= req.length;
      end else if (wr_en) begin
        wp        <= wp + WIN_AW'(1);
        remaining <= remaining - REM_W'(1);
        if (fill != FILL_W'(WINDOW_DEPTH)) begin
          fill <= fill + FILL_W'(1);
        end
      end

      if (take_lit) begin
        cnt_left <= '0;
      end else if (take_copy) begin
        cnt_left <= eff_len;
      end else if (issue) begin
        cnt_left <= cnt_left - LEN_W'(1);
      end

      if (take_lit) begin
        lane_n <= COUNT_W'(1);
      end else if (grp_push) begin
        lane_n <= '0;
      end else if (state == E_COPY && p_valid) begin
        lane_n <= lane_n + COUNT_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    p_fwd_data <= wr_data;
    p_zero     <= !written;
    if (take_copy) begin
      rd_addr <= req.pos;
    end else if (issue) begin
      rd_addr <= rd_addr + WIN_AW'(1);
    end
    for (int j = 0; j < LANE_SLOTS; j++) begin
      if (take_lit && j == 0) begin
        lanes[j] <= req.data;
      end else if (state == E_COPY && p_valid && lane_n[LANE_IW-1:0] == LANE_IW'(j)) begin
        lanes[j] <= arr_byte;
      end
    end
  end

  // A group never closes while a read is still returning
  a_push_no_inflight: assert property (@(posedge clk) disable iff (rst)
    grp_push |-> !p_valid)
    else $error("group closed with a read in flight");

  // The lane buffer never overfills
  a_lane_bound: assert property (@(posedge clk) disable iff (rst)
    lane_n <= COUNT_W'(LANES))
    else $error("lane buffer overflow");

  // Idle means nothing is buffered or in flight
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    idle |-> (lane_n == '0 && !p_valid))
    else $error("engine idle with pending bytes");

  // A returning byte always finds a free slot
  a_arrive_room: assert property (@(posedge clk) disable iff (rst)
    (state == E_COPY && p_valid) |-> lane_n < COUNT_W'(LANES))
    else $error("returning byte has no slot");

endmodule

`default_nettype wire

[rtl/core/lzss_window_decompressor.sv]
// LZSS window decompressor, top level: configuration register, token parser
// and result register. Depends on lzss_pkg and lzss_copy_engine.
//
// Usage:
//   cfg channel: write output_length (24 bits) while the block is idle; it
//   takes effect at the next start command (command = 1), which also clears
//   the 1024-byte window and restarts token parsing.
//   data channel: one compressed byte per transaction. Flag bytes and the
//   low byte of a reference only update the parser, so data_ready stays
//   high after them. A literal goes into the engine's lane buffer and is
//   closed as a group into the result register; the next byte is taken once
//   that group has closed. A reference of n bytes is read from the window at
//   one byte a cycle, pausing while a full group of four waits to close.
//   data_ready is low while the engine is busy; the window port sets the rate.
//   result channel: groups of up to four bytes, registered. When the receiver
//   stalls, one finished group waits in the result register and the engine
//   keeps working until its next group is complete.
// Reset: the window reads as zeros (a fill count tracks written entries, so
// no clearing pass is needed), output_length and the remaining count are 0,
// so data bytes are dropped until a start command arrives.
`default_nettype none

module lzss_window_decompressor (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     data_valid,
  output logic                          data_ready,
  input  wire lzss_pkg::in_item_t       data_item,
  output logic                          result_valid,
  input  wire logic                     result_ready,
  output lzss_pkg::out_item_t           result_item,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [lzss_pkg::REM_W-1:0] cfg_data
);
  import lzss_pkg::*;

  logic [REM_W-1:0] output_length;
  logic [15:0]      flag_shift, flag_shift_next;
  phase_t           parse_phase, parse_phase_next;
  logic [7:0]       held_low_byte, held_low_byte_next;

  logic             accept;
  logic [15:0]      flag_sh;
  eng_req_t         req;
  logic             eng_idle;
  logic [REM_W-1:0] remaining;
  logic             grp_push;
  logic             grp_free;
  out_item_t        grp;

  lzss_copy_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .grp_free  (grp_free),
    .idle      (eng_idle),
    .remaining (remaining),
    .grp_push  (grp_push),
    .grp       (grp)
  );

  assign cfg_ready  = 1'b1;
  assign data_ready = eng_idle;
  assign accept     = data_valid && data_ready;
  assign flag_sh    = {1'b0, flag_shift[15:1]};
  assign grp_free   = !result_valid || result_ready;

  // Parser next state
  always_comb begin
    flag_shift_next    = flag_shift;
    parse_phase_next   = parse_phase;
    held_low_byte_next = held_low_byte;
    if (accept) begin
      if (data_item.command) begin
        flag_shift_next    = '0;
        parse_phase_next   = PH_TOKEN;
        held_low_byte_next = '0;
      end else if (remaining != '0) begin
        case (parse_phase)
          PH_TOKEN: begin
            if (!flag_sh[8]) begin
              flag_shift_next  = FLAG_FILL | {8'h00, data_item.data_byte};
              parse_phase_next = PH_FLAG_DONE;
            end else begin
              flag_shift_next = flag_sh;
              if (!flag_sh[0]) begin
                held_low_byte_next = data_item.data_byte;
                parse_phase_next   = PH_HIGH;
              end
            end
          end
          PH_FLAG_DONE: begin
            if (flag_shift[0]) begin
              parse_phase_next = PH_TOKEN;
            end else begin
              held_low_byte_next = data_item.data_byte;
              parse_phase_next   = PH_HIGH;
            end
          end
          PH_HIGH: parse_phase_next = PH_TOKEN;
          default: parse_phase_next = PH_TOKEN;
        endcase
      end
    end
  end

  // Parser outputs: work for the copy engine
  always_comb begin
    req.kind   = REQ_NONE;
    req.data   = data_item.data_byte;
    req.pos    = {data_item.data_byte[7:6] & POS_MASK[7:6], held_low_byte};
    req.len    = LEN_W'(data_item.data_byte & LEN_MASK) + MIN_MATCH;
    req.length = output_length;
    if (accept) begin
      if (data_item.command) begin
        req.kind = REQ_START;
      end else if (remaining != '0) begin
        case (parse_phase)
          PH_TOKEN: begin
            if (flag_sh[8] && flag_sh[0]) begin
              req.kind = REQ_LITERAL;
            end
          end
          PH_FLAG_DONE: begin
            if (flag_shift[0]) begin
              req.kind = REQ_LITERAL;
            end
          end
          PH_HIGH: req.kind = REQ_COPY;
          default: req.kind = REQ_NONE;
        endcase
      end
    end
  end

  // Parser and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_shift    <= '0;
      parse_phase   <= PH_TOKEN;
      held_low_byte <= '0;
      output_length <= '0;
    end else begin
      flag_shift    <= flag_shift_next;
      parse_phase   <= parse_phase_next;
      held_low_byte <= held_low_byte_next;
      if (cfg_valid && cfg_ready) begin
        output_length <= cfg_data;
      end
    end
  end

  // Result register: load a closed group, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (grp_push) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_push) begin
      result_item <= grp;
    end
  end

endmodule

`default_nettype wire
